/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL. All checks are clocked on clk and
// masked while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define XDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every rising edge of clk outside reset.
`define XDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/xdc_pkg.sv */
// ----------------------------------------------------------------------------
// xdc_pkg
// Shared types and helpers for the distance constraint projection pipeline.
// ----------------------------------------------------------------------------
package xdc_pkg;

  // Item payload that travels the whole pipeline
  typedef struct packed {
    logic [2:0][31:0] pa;
    logic [2:0][31:0] pb;
    logic [31:0]      wa;
    logic [31:0]      wb;
    logic [31:0]      lam;
    logic             go;
  } item_t;

  // Square root section: one result bit per stage
  typedef struct packed {
    item_t            it;
    logic [2:0][32:0] d;
    logic [62:0]      alam;
    logic [33:0]      den;
    logic [30:0]      rest;
    logic [67:0]      rad;
    logic [33:0]      root;
    logic [36:0]      rem;
  } sq_t;

  // Division section: lane 0 is the multiplier update, lanes 1..3 the normal
  typedef struct packed {
    item_t            it;
    logic [3:0]       dneg;
    logic             sat;
    logic             skip;
    logic [33:0]      den;
    logic [33:0]      len;
    logic [3:0][33:0] p;
    logic [3:0][31:0] lq;
  } dv_t;

  function automatic logic [31:0] sat32(input logic signed [64:0] x);
    if (x > 65'sh7FFFFFFF) begin
      return 32'h7FFFFFFF;
    end else if (x < -65'sh80000000) begin
      return 32'h80000000;
    end
    return x[31:0];
  endfunction

endpackage

/* hw/rtl/xdc_sqrt_step.sv */
// ----------------------------------------------------------------------------
// xdc_sqrt_step
// One registered step of the restoring square root: one root bit per stage.
// ----------------------------------------------------------------------------
module xdc_sqrt_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  xdc_pkg::sq_t  dat_i,
  output logic          vld_o,
  output xdc_pkg::sq_t  dat_o
);
  import xdc_pkg::*;

  logic        vld_r;
  sq_t         dat_r;
  sq_t         dat_nxt;
  logic [36:0] remx;
  logic [36:0] trial;

  always_comb begin
    dat_nxt = dat_i;
    remx    = {dat_i.rem[34:0], dat_i.rad[67:66]};
    trial   = {1'b0, dat_i.root, 2'b01};
    dat_nxt.rad = {dat_i.rad[65:0], 2'b00};
    if (remx >= trial) begin
      dat_nxt.rem  = remx - trial;
      dat_nxt.root = {dat_i.root[32:0], 1'b1};
    end else begin
      dat_nxt.rem  = remx;
      dat_nxt.root = {dat_i.root[32:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

/* hw/rtl/xdc_div_step.sv */
// ----------------------------------------------------------------------------
// xdc_div_step
// One registered restoring division step on four independent lanes.
// ----------------------------------------------------------------------------
module xdc_div_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  xdc_pkg::dv_t  dat_i,
  output logic          vld_o,
  output xdc_pkg::dv_t  dat_o
);
  import xdc_pkg::*;

  logic        vld_r;
  dv_t         dat_r;
  dv_t         dat_nxt;
  logic [34:0] px  [4];
  logic [34:0] dvs [4];

  always_comb begin
    dat_nxt = dat_i;
    for (int k = 0; k < 4; k++) begin
      dvs[k] = (k == 0) ? {1'b0, dat_i.den} : {1'b0, dat_i.len};
      px[k]  = {dat_i.p[k], dat_i.lq[k][31]};
      if (px[k] >= dvs[k]) begin
        dat_nxt.p[k]  = 34'(px[k] - dvs[k]);
        dat_nxt.lq[k] = {dat_i.lq[k][30:0], 1'b1};
      end else begin
        dat_nxt.p[k]  = px[k][33:0];
        dat_nxt.lq[k] = {dat_i.lq[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

/* hw/rtl/xpbd_distance_constraint.sv */
// Depth: 76 register stages. Throughput: one constraint per cycle unless the
// output stalls; the 34-stage square root and the 32-stage divider are fully
// pipelined, so the deepest loop sets latency only.
// A stalled output freezes every stage at once; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and loads
// inv_substep_squared with 3600.
// ----------------------------------------------------------------------------
// xpbd_distance_constraint
// XPBD distance constraint projection in Q16.16 fixed point, deep pipeline.
// ----------------------------------------------------------------------------
module xpbd_distance_constraint (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [23:0]  cfg_wr_data,   // inv_substep_squared
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, weight_a, weight_b,
  // rest_len[30:0], compliance, multiplier_in, one pad bit
  input  logic [351:0] in_tdata,
  input  logic         in_tuser,      // constraint_active
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z, multiplier_out
  output logic [223:0] out_tdata,
  output logic         out_tuser      // applied
);
  import xdc_pkg::*;
  `include "assert_macros.svh"

  localparam int SQ_STEPS = 34;
  localparam int DV_STEPS = 32;

  // global advance: every stage moves when the output register can take data
  logic en;

  logic [23:0] cfg_r;

  // stage 1: differences and magnitudes, compliance product
  logic             f1_vld_r;
  item_t            f1_it_r;
  logic [2:0][32:0] f1_d_r;
  logic [2:0][31:0] f1_mag_r;
  logic [55:0]      f1_ap_r;
  logic [30:0]      f1_rest_r;

  // stage 2: squares and alpha
  logic             f2_vld_r;
  item_t            f2_it_r;
  logic [2:0][32:0] f2_d_r;
  logic [2:0][63:0] f2_sq_r;
  logic [30:0]      f2_alpha_r;
  logic [30:0]      f2_rest_r;

  // stage 3 feeds the square root chain
  logic f3_vld_r;
  sq_t  f3_dat_r;
  sq_t  f3_nxt;

  logic sq_vld [SQ_STEPS+1];
  sq_t  sq_dat [SQ_STEPS+1];

  // numerator stage
  logic               p1_vld_r;
  item_t              p1_it_r;
  logic [2:0][32:0]   p1_d_r;
  logic [33:0]        p1_den_r;
  logic [33:0]        p1_len_r;
  logic signed [64:0] p1_num_r;
  logic               p1_skip_r;

  // divider entry
  logic p2_vld_r;
  dv_t  p2_dat_r;
  dv_t  p2_nxt;

  logic dv_vld [DV_STEPS+1];
  dv_t  dv_dat [DV_STEPS+1];

  // back end
  logic               q1_vld_r;
  item_t              q1_it_r;
  logic               q1_skip_r;
  logic [31:0]        q1_dl_r;
  logic [2:0][31:0]   q1_n_r;

  logic               q2_vld_r;
  item_t              q2_it_r;
  logic               q2_skip_r;
  logic [31:0]        q2_dl_r;
  logic [2:0][31:0]   q2_n_r;
  logic signed [64:0] q2_wpa_r;
  logic signed [64:0] q2_wpb_r;

  logic               q3_vld_r;
  item_t              q3_it_r;
  logic               q3_skip_r;
  logic [31:0]        q3_dl_r;
  logic [2:0][31:0]   q3_n_r;
  logic [31:0]        q3_sa_r;
  logic [31:0]        q3_sb_r;

  logic               q4_vld_r;
  item_t              q4_it_r;
  logic               q4_skip_r;
  logic [31:0]        q4_dl_r;
  logic [2:0][63:0]   q4_ca_r;
  logic [2:0][63:0]   q4_cb_r;

  logic         out_vld_r;
  logic [223:0] out_dat_r;
  logic         out_app_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= 24'd3600;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------- stage 1
  item_t            s1_it;
  logic [2:0][32:0] s1_d;
  logic [2:0][31:0] s1_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_it.pa[i] = in_tdata[32*i +: 32];
      s1_it.pb[i] = in_tdata[96 + 32*i +: 32];
      s1_d[i]     = {s1_it.pb[i][31], s1_it.pb[i]} - {s1_it.pa[i][31], s1_it.pa[i]};
      s1_mag[i]   = s1_d[i][32] ? 32'(-s1_d[i]) : s1_d[i][31:0];
    end
    s1_it.wa  = in_tdata[223:192];
    s1_it.wb  = in_tdata[255:224];
    s1_it.lam = in_tdata[350:319];
    s1_it.go  = in_tuser && ((s1_it.wa != 32'd0) || (s1_it.wb != 32'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_tvalid;
    end
    if (en) begin
      f1_it_r   <= s1_it;
      f1_d_r    <= s1_d;
      f1_mag_r  <= s1_mag;
      f1_ap_r   <= {24'd0, in_tdata[318:287]} * {32'd0, cfg_r};
      f1_rest_r <= in_tdata[286:256];
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [56:0] s2_ar;

  always_comb begin
    s2_ar = {1'b0, f1_ap_r} + 57'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f2_vld_r <= f1_vld_r;
    end
    if (en) begin
      f2_it_r    <= f1_it_r;
      f2_d_r     <= f1_d_r;
      f2_rest_r  <= f1_rest_r;
      // round alpha to Q16.16 and clamp to the positive signed range
      f2_alpha_r <= (s2_ar[56:47] != 10'd0) ? 31'h7FFFFFFF : s2_ar[46:16];
      for (int i = 0; i < 3; i++) begin
        f2_sq_r[i] <= {32'd0, f1_mag_r[i]} * {32'd0, f1_mag_r[i]};
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [63:0] s3_alam;

  always_comb begin
    s3_alam         = $signed({1'b0, f2_alpha_r}) * $signed(f2_it_r.lam);
    f3_nxt.it       = f2_it_r;
    f3_nxt.d        = f2_d_r;
    f3_nxt.alam     = s3_alam[62:0];
    f3_nxt.den      = {2'b0, f2_it_r.wa} + {2'b0, f2_it_r.wb} + {3'b0, f2_alpha_r};
    f3_nxt.rest     = f2_rest_r;
    f3_nxt.rad      = {4'b0, f2_sq_r[0]} + {4'b0, f2_sq_r[1]} + {4'b0, f2_sq_r[2]};
    f3_nxt.root     = '0;
    f3_nxt.rem      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_vld_r <= 1'b0;
    end else if (en) begin
      f3_vld_r <= f2_vld_r;
    end
    if (en) begin
      f3_dat_r <= f3_nxt;
    end
  end

  // ------------------------------------------------------ square root chain
  assign sq_vld[0] = f3_vld_r;
  assign sq_dat[0] = f3_dat_r;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    xdc_sqrt_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (sq_vld[g]),
      .dat_i (sq_dat[g]),
      .vld_o (sq_vld[g+1]),
      .dat_o (sq_dat[g+1])
    );
  end

  // ------------------------------------------------- numerator of dlambda
  logic signed [34:0] n1_c;
  logic signed [62:0] n1_alam;
  logic signed [64:0] n1_num;

  always_comb begin
    n1_c    = $signed({1'b0, sq_dat[SQ_STEPS].root}) - $signed({4'b0, sq_dat[SQ_STEPS].rest});
    n1_alam = $signed(sq_dat[SQ_STEPS].alam);
    n1_num  = -(65'(n1_c) <<< 16) - 65'(n1_alam);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= sq_vld[SQ_STEPS];
    end
    if (en) begin
      p1_it_r   <= sq_dat[SQ_STEPS].it;
      p1_d_r    <= sq_dat[SQ_STEPS].d;
      p1_den_r  <= sq_dat[SQ_STEPS].den;
      p1_len_r  <= sq_dat[SQ_STEPS].root;
      p1_num_r  <= n1_num;
      // skip when inactive, weightless or the endpoints coincide
      p1_skip_r <= !sq_dat[SQ_STEPS].it.go || (sq_dat[SQ_STEPS].root == 34'd0);
    end
  end

  // ------------------------------------------------------- divider set-up
  logic [64:0]      n2_abs;
  logic [2:0][31:0] n2_ad;

  always_comb begin
    n2_abs           = p1_num_r[64] ? 65'(-p1_num_r) : p1_num_r;
    p2_nxt.it        = p1_it_r;
    p2_nxt.skip      = p1_skip_r;
    p2_nxt.den       = p1_den_r;
    p2_nxt.len       = p1_len_r;
    p2_nxt.dneg[0]   = p1_num_r[64];
    // quotient would not fit in 32 bits: clamp later
    p2_nxt.sat       = {2'b0, n2_abs[63:0]} >= {p1_den_r, 32'd0};
    p2_nxt.p[0]      = {2'b0, n2_abs[63:32]};
    p2_nxt.lq[0]     = n2_abs[31:0];
    for (int i = 0; i < 3; i++) begin
      n2_ad[i]         = p1_d_r[i][32] ? 32'(-p1_d_r[i]) : p1_d_r[i][31:0];
      p2_nxt.dneg[i+1] = p1_d_r[i][32];
      // dividend is |d| scaled by 2^30
      p2_nxt.p[i+1]    = {4'b0, n2_ad[i][31:2]};
      p2_nxt.lq[i+1]   = {n2_ad[i][1:0], 30'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
    if (en) begin
      p2_dat_r <= p2_nxt;
    end
  end

  // --------------------------------------------------------- divider chain
  assign dv_vld[0] = p2_vld_r;
  assign dv_dat[0] = p2_dat_r;

  for (genvar g = 0; g < DV_STEPS; g++) begin : g_div
    xdc_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (dv_vld[g]),
      .dat_i (dv_dat[g]),
      .vld_o (dv_vld[g+1]),
      .dat_o (dv_dat[g+1])
    );
  end

  // ------------------------------------------------- signed quotients
  logic [31:0]      b1_q0;
  logic [31:0]      b1_dl;
  logic [2:0][31:0] b1_n;

  always_comb begin
    b1_q0 = dv_dat[DV_STEPS].lq[0];
    if (dv_dat[DV_STEPS].sat) begin
      b1_dl = dv_dat[DV_STEPS].dneg[0] ? 32'h80000000 : 32'h7FFFFFFF;
    end else if (dv_dat[DV_STEPS].dneg[0]) begin
      b1_dl = (b1_q0 > 32'h80000000) ? 32'h80000000 : 32'(-b1_q0);
    end else begin
      b1_dl = b1_q0[31] ? 32'h7FFFFFFF : b1_q0;
    end
    for (int i = 0; i < 3; i++) begin
      b1_n[i] = dv_dat[DV_STEPS].dneg[i+1] ? 32'(-dv_dat[DV_STEPS].lq[i+1])
                                            : dv_dat[DV_STEPS].lq[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_vld_r <= 1'b0;
    end else if (en) begin
      q1_vld_r <= dv_vld[DV_STEPS];
    end
    if (en) begin
      q1_it_r   <= dv_dat[DV_STEPS].it;
      q1_skip_r <= dv_dat[DV_STEPS].skip;
      q1_dl_r   <= b1_dl;
      q1_n_r    <= b1_n;
    end
  end

  // ------------------------------------------------ weight times dlambda
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_vld_r <= 1'b0;
    end else if (en) begin
      q2_vld_r <= q1_vld_r;
    end
    if (en) begin
      q2_it_r   <= q1_it_r;
      q2_skip_r <= q1_skip_r;
      q2_dl_r   <= q1_dl_r;
      q2_n_r    <= q1_n_r;
      q2_wpa_r  <= $signed({1'b0, q1_it_r.wa}) * $signed(q1_dl_r);
      q2_wpb_r  <= $signed({1'b0, q1_it_r.wb}) * $signed(q1_dl_r);
    end
  end

  // ------------------------------------------------ round to step lengths
  logic signed [64:0] b3_ra;
  logic signed [64:0] b3_rb;

  always_comb begin
    b3_ra = (q2_wpa_r + 65'sd32768) >>> 16;
    b3_rb = (q2_wpb_r + 65'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q3_vld_r <= 1'b0;
    end else if (en) begin
      q3_vld_r <= q2_vld_r;
    end
    if (en) begin
      q3_it_r   <= q2_it_r;
      q3_skip_r <= q2_skip_r;
      q3_dl_r   <= q2_dl_r;
      q3_n_r    <= q2_n_r;
      q3_sa_r   <= sat32(b3_ra);
      q3_sb_r   <= sat32(b3_rb);
    end
  end

  // ---------------------------------------------- step times unit normal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q4_vld_r <= 1'b0;
    end else if (en) begin
      q4_vld_r <= q3_vld_r;
    end
    if (en) begin
      q4_it_r   <= q3_it_r;
      q4_skip_r <= q3_skip_r;
      q4_dl_r   <= q3_dl_r;
      for (int i = 0; i < 3; i++) begin
        q4_ca_r[i] <= $signed(q3_sa_r) * $signed(q3_n_r[i]);
        q4_cb_r[i] <= $signed(q3_sb_r) * $signed(q3_n_r[i]);
      end
    end
  end

  // ------------------------------------------- apply and output register
  logic signed [63:0] b5_ca [3];
  logic signed [63:0] b5_cb [3];
  logic [223:0]       b5_dat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b5_ca[i] = ($signed(q4_ca_r[i]) + 64'sd536870912) >>> 30;
      b5_cb[i] = ($signed(q4_cb_r[i]) + 64'sd536870912) >>> 30;
      if (q4_skip_r) begin
        b5_dat[32*i +: 32]      = q4_it_r.pa[i];
        b5_dat[96 + 32*i +: 32] = q4_it_r.pb[i];
      end else begin
        b5_dat[32*i +: 32]      = sat32(65'($signed(q4_it_r.pa[i])) - 65'(b5_ca[i]));
        b5_dat[96 + 32*i +: 32] = sat32(65'($signed(q4_it_r.pb[i])) + 65'(b5_cb[i]));
      end
    end
    b5_dat[223:192] = q4_skip_r ? q4_it_r.lam
                    : sat32(65'($signed(q4_it_r.lam)) + 65'($signed(q4_dl_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= q4_vld_r;
    end
    if (en) begin
      out_dat_r <= b5_dat;
      out_app_r <= !q4_skip_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;
  assign out_tuser  = out_app_r;

  // ------------------------------------------------------------ assertions
  // square root remainder never exceeds twice the root
  `XDC_ASSERT_IMP(a_sqrt_rem, sq_vld[SQ_STEPS],
    {2'b0, sq_dat[SQ_STEPS].rem} <= {4'b0, sq_dat[SQ_STEPS].root, 1'b0},
    "square root remainder out of range")
  // normal lane remainder stays below the length on a solved constraint
  `XDC_ASSERT_IMP(a_div_rem, dv_vld[DV_STEPS] && !dv_dat[DV_STEPS].skip,
    dv_dat[DV_STEPS].p[1] < dv_dat[DV_STEPS].len,
    "normal division remainder not below length")
  // unit normal y component never exceeds one in Q2.30
  `XDC_ASSERT_IMP(a_norm_mag, dv_vld[DV_STEPS] && !dv_dat[DV_STEPS].skip,
    dv_dat[DV_STEPS].lq[2] <= 32'h40000000,
    "normal component above unity")

endmodule
